### rtl/chunked_body_decoder_unit_defines.svh
// ----------------------------------------------------------------------------
// Chunked body decoder - assertion macros
// Shared property wrappers for the decoder modules; clocked on clk and
// disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef CHUNKED_BODY_DECODER_UNIT_DEFINES_SVH
`define CHUNKED_BODY_DECODER_UNIT_DEFINES_SVH

// Same-cycle implication
`define CBD_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define CBD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/cbd_pkg.sv
// ----------------------------------------------------------------------------
// Chunked body decoder - package
// Item types, register indexes, character codes and the hex digit decoder.
// ----------------------------------------------------------------------------
package cbd_pkg;

	localparam int SIZE_BITS_DEF = 32;
	localparam int SUM_W         = 32;
	localparam int CFG_IDX_W     = 2;
	localparam int CFG_DATA_W    = 32;

	localparam logic [7:0] CHAR_CR = 8'h0D;
	localparam logic [7:0] CHAR_LF = 8'h0A;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CHUNKED_MODE      = 2'd0,
		CFG_BODY_LENGTH_LIMIT = 2'd1
	} cfg_idx_t;

	typedef struct packed {
		logic             chunked_mode;
		logic [SUM_W-1:0] body_length_limit;
	} cfg_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       start_body;
	} in_item_t;

	typedef struct packed {
		logic [7:0]       payload_byte;
		logic             payload_valid;
		logic             consumed;
		logic             body_done;
		logic             framing_error;
		logic [SUM_W-1:0] total_length;
	} out_item_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] val;
	} hex_t;

	// Letters A-F and a-f both carry value low nibble plus nine
	function automatic hex_t hex_decode(input logic [7:0] c);
		hex_t h;
		h.ok  = 1'b0;
		h.val = c[3:0];
		if (c inside {[8'h30:8'h39]}) begin
			h.ok = 1'b1;
		end else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
			h.ok  = 1'b1;
			h.val = c[3:0] + 4'd9;
		end
		return h;
	endfunction

endpackage

### rtl/cbd_cfg_regs.sv
// ----------------------------------------------------------------------------
// Chunked body decoder - configuration registers
// Holds the mode select and the fixed body length.
// ----------------------------------------------------------------------------
module cbd_cfg_regs
	import cbd_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [CFG_IDX_W-1:0]  wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			case (wr_index)
				CFG_CHUNKED_MODE:      cfg_q.chunked_mode <= wr_data[0];
				CFG_BODY_LENGTH_LIMIT: cfg_q.body_length_limit <= wr_data[SUM_W-1:0];
				default: ; // drop writes to unused indexes
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### rtl/cbd_core.sv
// ----------------------------------------------------------------------------
// Chunked body decoder - decode core
// Framing state and the per-byte next-state logic; state moves on advance.
// ----------------------------------------------------------------------------
`include "chunked_body_decoder_unit_defines.svh"

module cbd_core
	import cbd_pkg::*;
#(
	parameter int SIZE_BITS = SIZE_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_t      cfg,
	input  in_item_t  item,
	input  logic      advance,
	output out_item_t result
);

	localparam int ACC_W = ((SIZE_BITS > SUM_W) ? SIZE_BITS : SUM_W) + 1;

	logic                 size_known_q, saw_cr_q, done_q, error_q;
	logic [SIZE_BITS-1:0] chunk_size_q, bytes_left_q;
	logic [SUM_W-1:0]     length_sum_q;

	logic                 cur_size_known, cur_saw_cr, cur_done, cur_err;
	logic [SIZE_BITS-1:0] cur_chunk, cur_left;
	logic [SUM_W-1:0]     cur_sum;

	logic                 nxt_size_known, nxt_saw_cr, nxt_done, nxt_err;
	logic [SIZE_BITS-1:0] nxt_chunk, nxt_left;
	logic [SUM_W-1:0]     nxt_sum;

	logic                 pay, took;
	logic [7:0]           c;
	hex_t                 hexd;
	logic [ACC_W-1:0]     acc;
	logic [SUM_W-1:0]     sum_sat;
	logic [SUM_W-1:0]     sum_inc;

	assign c = item.data_byte;
	assign hexd = hex_decode(c);

	// A new body starts from cleared state before this byte is looked at
	always_comb begin
		cur_size_known = item.start_body ? 1'b0 : size_known_q;
		cur_saw_cr     = item.start_body ? 1'b0 : saw_cr_q;
		cur_done       = item.start_body ? 1'b0 : done_q;
		cur_err        = item.start_body ? 1'b0 : error_q;
		cur_chunk      = item.start_body ? '0 : chunk_size_q;
		cur_left       = item.start_body ? '0 : bytes_left_q;
		cur_sum        = item.start_body ? '0 : length_sum_q;
	end

	assign acc     = ACC_W'(cur_chunk) + ACC_W'(cur_sum);
	assign sum_sat = (acc[ACC_W-1:SUM_W] != '0) ? '1 : acc[SUM_W-1:0];
	assign sum_inc = cur_sum + SUM_W'(1);

	always_comb begin
		nxt_size_known = cur_size_known;
		nxt_saw_cr     = cur_saw_cr;
		nxt_done       = cur_done;
		nxt_err        = cur_err;
		nxt_chunk      = cur_chunk;
		nxt_left       = cur_left;
		nxt_sum        = cur_sum;
		pay            = 1'b0;
		took           = 1'b0;
		if (cur_done || cur_err) begin
			// hold: nothing is taken once the body is over
		end else if (cfg.chunked_mode) begin
			if (!cur_size_known) begin
				if (c == CHAR_LF) begin
					nxt_size_known = 1'b1;
					nxt_saw_cr     = 1'b0;
					nxt_sum        = sum_sat;
					nxt_left       = cur_chunk;
					nxt_done       = (cur_chunk == '0);
					took           = 1'b1;
				end else if (c == CHAR_CR && !cur_saw_cr) begin
					nxt_saw_cr = 1'b1;
					took       = 1'b1;
				end else if (hexd.ok && !cur_saw_cr) begin
					// a digit with the top nibble in use would overflow the size
					if (cur_chunk[SIZE_BITS-1 -: 4] != 4'd0) begin
						nxt_err = 1'b1;
					end else begin
						nxt_chunk = {cur_chunk[SIZE_BITS-5:0], hexd.val};
						took      = 1'b1;
					end
				end else begin
					nxt_err = 1'b1;
				end
			end else if (cur_left != '0) begin
				nxt_left = cur_left - SIZE_BITS'(1);
				pay      = 1'b1;
				took     = 1'b1;
			end else if (c == CHAR_CR && !cur_saw_cr) begin
				nxt_saw_cr = 1'b1;
				took       = 1'b1;
			end else if (c == CHAR_LF) begin
				nxt_saw_cr     = 1'b0;
				nxt_size_known = 1'b0;
				nxt_chunk      = '0;
				took           = 1'b1;
			end else begin
				nxt_err = 1'b1;
			end
		end else begin
			if (cur_sum >= cfg.body_length_limit) begin
				nxt_done = 1'b1;
			end else begin
				nxt_sum  = sum_inc;
				pay      = 1'b1;
				took     = 1'b1;
				nxt_done = (sum_inc == cfg.body_length_limit);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_known_q <= 1'b0;
			saw_cr_q     <= 1'b0;
			done_q       <= 1'b0;
			error_q      <= 1'b0;
			chunk_size_q <= '0;
			bytes_left_q <= '0;
			length_sum_q <= '0;
		end else if (advance) begin
			size_known_q <= nxt_size_known;
			saw_cr_q     <= nxt_saw_cr;
			done_q       <= nxt_done;
			error_q      <= nxt_err;
			chunk_size_q <= nxt_chunk;
			bytes_left_q <= nxt_left;
			length_sum_q <= nxt_sum;
		end
	end

	always_comb begin
		result.payload_byte  = pay ? c : 8'd0;
		result.payload_valid = pay;
		result.consumed      = took;
		result.body_done     = nxt_done;
		result.framing_error = nxt_err;
		result.total_length  = nxt_sum;
	end

	`CBD_ASSERT_NEXT(a_error_sticky, error_q && !(advance && item.start_body),
		error_q, "framing error cleared without a new body")
	`CBD_ASSERT_NEXT(a_done_sticky, done_q && !(advance && item.start_body),
		done_q, "body done cleared without a new body")
	`CBD_ASSERT_NOW(a_idle_after_end, advance && (done_q || error_q) && !item.start_body,
		!result.consumed, "byte consumed after the body ended")

endmodule

### rtl/chunked_body_decoder_unit.sv
// A byte waits in the input register; once it advances, its result is
// registered and offered. One byte per cycle while no stall backs up results.
// Input register and result register give one item of slack under a stall.
// Reset (arst_n low, asynchronous): configuration, framing state and both
// registers' valid flags clear; bytes can be taken as soon as it is released.
// ----------------------------------------------------------------------------
// Chunked body decoder - top level
// HTTP body byte decoder for chunked and fixed-length transfer.
// ----------------------------------------------------------------------------
`include "chunked_body_decoder_unit_defines.svh"

module chunked_body_decoder_unit
	import cbd_pkg::*;
#(
	parameter int SIZE_BITS = SIZE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  byte_valid,
	output logic                  byte_stall,
	input  in_item_t              byte_item,
	output logic                  res_valid,
	input  logic                  res_stall,
	output out_item_t             res_item
);

	cfg_t      cfg;
	in_item_t  item_s1;
	logic      valid_s1;
	out_item_t res_next;
	out_item_t res_q;
	logic      res_valid_q;
	logic      advance;
	logic      take_in;

	assign cfg_ready = 1'b1;

	cbd_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// advance the held byte when the result register is free or draining
	assign advance    = valid_s1 && (!res_valid_q || !res_stall);
	assign byte_stall = valid_s1 && !advance;
	assign take_in    = byte_valid && !byte_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take_in || advance) begin
			valid_s1 <= take_in;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			item_s1 <= byte_item;
		end
	end

	cbd_core #(
		.SIZE_BITS (SIZE_BITS)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.item    (item_s1),
		.advance (advance),
		.result  (res_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_next;
		end
	end

	assign res_valid = res_valid_q;
	assign res_item  = res_q;

	`CBD_ASSERT_NOW(a_payload_consumed, res_valid_q && res_q.payload_valid,
		res_q.consumed, "payload item not marked consumed")
	`CBD_ASSERT_NOW(a_payload_no_error, res_valid_q && res_q.payload_valid,
		!res_q.framing_error, "payload item carries framing error")
	`CBD_ASSERT_NEXT(a_hold_s1, valid_s1 && !advance,
		valid_s1 && $stable(item_s1), "held input byte lost")

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Chunked body decoder - testbench
// Drives HTTP body bytes in both transfer modes through the byte channel,
// predicts every result item from a cycle-free model of the framing rules and
// checks the result channel field by field, under random bursts and stalls.
// ----------------------------------------------------------------------------
module testbench;
	import cbd_pkg::*;

	localparam int RANDOM_ITEMS   = 2000;
	localparam int MAX_REPORTS    = 10;
	localparam int HOLDOFF_CYCLES = 400;

	logic                  clk        = 1'b0;
	logic                  arst_n     = 1'b0;
	logic                  cfg_valid  = 1'b0;
	logic                  cfg_ready;
	cfg_idx_t              cfg_index  = CFG_CHUNKED_MODE;
	logic [CFG_DATA_W-1:0] cfg_data   = '0;
	logic                  byte_valid = 1'b0;
	logic                  byte_stall;
	in_item_t              byte_item  = '0;
	logic                  res_valid;
	logic                  res_stall  = 1'b0;
	out_item_t             res_item;

	chunked_body_decoder_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.byte_item  (byte_item),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.res_item   (res_item)
	);

	// Register copies and framing state of the decoder as predicted
	logic                     mode_chunked = 1'b0;
	logic [SUM_W-1:0]         len_limit    = '0;
	logic                     size_seen    = 1'b0;
	logic                     cr_seen      = 1'b0;
	logic                     body_end     = 1'b0;
	logic                     frame_err    = 1'b0;
	logic [SIZE_BITS_DEF-1:0] chunk_len    = '0;
	logic [SIZE_BITS_DEF-1:0] remaining    = '0;
	logic [SUM_W-1:0]         sum_len      = '0;

	in_item_t   byte_feed[$];
	out_item_t  predicted_results[$];
	logic [7:0] body_buf[$];
	int         fed_items   = 0;
	int         fault_count = 0;
	int         burst_left  = 0;
	int         gap_left    = 0;
	int         hold_cycles = 0;
	int         stall_seg   = 0;
	int         stall_pct   = 0;
	bit         holdoff_req = 1'b0;

	initial begin
		forever #1 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("Regression FAIL");
		$finish;
	end

	function automatic out_item_t decode_byte(input in_item_t it);
		out_item_t  r;
		logic [7:0] c;
		logic [3:0] nib;
		logic       is_hex;
		logic       passed;
		logic       took;
		c      = it.data_byte;
		passed = 1'b0;
		took   = 1'b0;
		is_hex = 1'b1;
		nib    = '0;
		if (c >= "0" && c <= "9")
			nib = 4'(c - "0");
		else if (c >= "A" && c <= "F")
			nib = 4'(c - "A" + 8'd10);
		else if (c >= "a" && c <= "f")
			nib = 4'(c - "a" + 8'd10);
		else
			is_hex = 1'b0;

		if (it.start_body) begin
			size_seen = 1'b0;
			cr_seen   = 1'b0;
			chunk_len = '0;
			remaining = '0;
			sum_len   = '0;
			body_end  = 1'b0;
			frame_err = 1'b0;
		end

		if (!(body_end || frame_err)) begin
			if (mode_chunked) begin
				if (!size_seen) begin
					if (c == CHAR_LF) begin
						size_seen = 1'b1;
						cr_seen   = 1'b0;
						// saturate the running total
						sum_len   = (chunk_len > ~sum_len) ? '1 : sum_len + chunk_len;
						remaining = chunk_len;
						if (chunk_len == 0)
							body_end = 1'b1;
						took = 1'b1;
					end else if (c == CHAR_CR && !cr_seen) begin
						cr_seen = 1'b1;
						took    = 1'b1;
					end else if (is_hex && !cr_seen) begin
						if (chunk_len[SIZE_BITS_DEF-1 -: 4] != 0) begin
							frame_err = 1'b1;
						end else begin
							chunk_len = {chunk_len[SIZE_BITS_DEF-5:0], nib};
							took      = 1'b1;
						end
					end else begin
						frame_err = 1'b1;
					end
				end else if (remaining != 0) begin
					remaining--;
					passed = 1'b1;
					took   = 1'b1;
				end else if (c == CHAR_CR && !cr_seen) begin
					cr_seen = 1'b1;
					took    = 1'b1;
				end else if (c == CHAR_LF) begin
					cr_seen   = 1'b0;
					size_seen = 1'b0;
					chunk_len = '0;
					took      = 1'b1;
				end else begin
					frame_err = 1'b1;
				end
			end else if (sum_len >= len_limit) begin
				body_end = 1'b1;
			end else begin
				sum_len++;
				passed = 1'b1;
				took   = 1'b1;
				if (sum_len == len_limit)
					body_end = 1'b1;
			end
		end

		r.payload_byte  = passed ? c : 8'h00;
		r.payload_valid = passed;
		r.consumed      = took;
		r.body_done     = body_end;
		r.framing_error = frame_err;
		r.total_length  = sum_len;
		return r;
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] n, input bit upper);
		if (n < 4'd10)
			return {4'h3, n};
		return (upper ? 8'h41 : 8'h61) + {4'h0, n - 4'd10};
	endfunction

	task automatic add_text(input string s);
		foreach (s[i])
			body_buf.push_back(s[i]);
	endtask

	// Size line: optional leading zeros, hex digits unless bare, optional CR, LF
	task automatic add_size_line(input logic [31:0] v, input int zeros, input bit upper,
			input bit bare);
		int top;
		top = 7;
		while (top > 0 && v[top*4 +: 4] == 0)
			top--;
		if (!bare) begin
			repeat (zeros) body_buf.push_back("0");
			for (int i = top; i >= 0; i--)
				body_buf.push_back(hex_char(v[i*4 +: 4], upper));
		end
		if ($urandom_range(0, 1))
			body_buf.push_back(CHAR_CR);
		body_buf.push_back(CHAR_LF);
	endtask

	task automatic add_chunked_body();
		int chunks;
		int len;
		chunks = $urandom_range(1, 4);
		repeat (chunks) begin
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 300) : $urandom_range(1, 16);
			add_size_line(len, $urandom_range(0, 2), 1'($urandom_range(0, 1)), 1'b0);
			repeat (len) body_buf.push_back(8'($urandom_range(0, 255)));
			if ($urandom_range(0, 1))
				body_buf.push_back(CHAR_CR);
			body_buf.push_back(CHAR_LF);
		end
		add_size_line(0, $urandom_range(0, 1), 1'b0, $urandom_range(0, 9) == 0);
		// trailing CRLF stays unconsumed
		body_buf.push_back(CHAR_CR);
		body_buf.push_back(CHAR_LF);
	endtask

	task automatic add_length_body();
		int n;
		n = (len_limit <= 40) ? $urandom_range(0, len_limit + 3) : $urandom_range(1, 40);
		repeat (n) body_buf.push_back(8'($urandom_range(0, 255)));
	endtask

	task automatic queue_body(input bit with_start, input bit may_corrupt);
		in_item_t it;
		if (may_corrupt && body_buf.size() != 0 && $urandom_range(0, 6) == 0)
			body_buf[$urandom_range(0, body_buf.size() - 1)] = 8'($urandom_range(0, 255));
		foreach (body_buf[i]) begin
			it.data_byte  = body_buf[i];
			it.start_body = (i == 0) && with_start;
			byte_feed.push_back(it);
			fed_items++;
		end
		body_buf.delete();
	endtask

	// Random bytes with random start marks anywhere
	task automatic queue_noise();
		in_item_t it;
		repeat ($urandom_range(1, 10)) begin
			it.data_byte  = 8'($urandom_range(0, 255));
			it.start_body = ($urandom_range(0, 3) == 0);
			byte_feed.push_back(it);
			fed_items++;
		end
	endtask

	// Called at a rising edge; returns at a later rising edge with the channel idle
	task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_CHUNKED_MODE:      mode_chunked = val[0];
			CFG_BODY_LENGTH_LIMIT: len_limit    = val;
			default: ;
		endcase
		@(posedge clk);
	endtask

	// Wait until every queued item has been taken and every result has come back
	task automatic drain();
		do
			@(negedge clk);
		while (byte_feed.size() != 0 || byte_valid || predicted_results.size() != 0);
		repeat (4) @(negedge clk);
		@(posedge clk);
	endtask

	// Sender: bursts of random length with random gaps
	always @(posedge clk) begin
		if (!arst_n) begin
			byte_valid <= 1'b0;
		end else begin
			if (byte_valid && !byte_stall)
				predicted_results.push_back(decode_byte(byte_item));
			if (!byte_valid || !byte_stall) begin
				if (gap_left != 0) begin
					gap_left--;
					byte_valid <= 1'b0;
				end else if (byte_feed.size() != 0) begin
					byte_item  <= byte_feed.pop_front();
					byte_valid <= 1'b1;
					if (burst_left > 1) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(1, 48);
						gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
					end
				end else begin
					byte_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: stall density changes per segment, plus occasional long hold-offs
	always @(posedge clk) begin
		if (!arst_n) begin
			res_stall <= 1'b0;
		end else if (hold_cycles != 0) begin
			hold_cycles--;
			res_stall <= 1'b1;
		end else if (holdoff_req) begin
			holdoff_req = 1'b0;
			hold_cycles = HOLDOFF_CYCLES;
			res_stall <= 1'b1;
		end else if ($urandom_range(0, 4999) == 0) begin
			hold_cycles = $urandom_range(50, 150);
			res_stall <= 1'b1;
		end else begin
			if (stall_seg == 0) begin
				stall_seg = $urandom_range(10, 200);
				case ($urandom_range(0, 3))
					0:       stall_pct = 0;
					1:       stall_pct = 25;
					2:       stall_pct = 50;
					default: stall_pct = 90;
				endcase
			end
			stall_seg--;
			res_stall <= ($urandom_range(0, 99) < stall_pct);
		end
	end

	// Result check against the oldest prediction
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && res_valid && !res_stall) begin
			if (predicted_results.size() == 0) begin
				fault_count++;
				if (fault_count <= MAX_REPORTS)
					$display("unexpected result item: %p", res_item);
			end else begin
				want = predicted_results.pop_front();
				if (res_item.payload_byte !== want.payload_byte
						|| res_item.payload_valid !== want.payload_valid
						|| res_item.consumed !== want.consumed
						|| res_item.body_done !== want.body_done
						|| res_item.framing_error !== want.framing_error
						|| res_item.total_length !== want.total_length) begin
					fault_count++;
					if (fault_count <= MAX_REPORTS)
						$display("mismatch: expected byte=%02h pv=%b cons=%b done=%b err=%b len=%0d",
							want.payload_byte, want.payload_valid, want.consumed,
							want.body_done, want.framing_error, want.total_length,
							"\n          actual   byte=%02h pv=%b cons=%b done=%b err=%b len=%0d",
							res_item.payload_byte, res_item.payload_valid, res_item.consumed,
							res_item.body_done, res_item.framing_error, res_item.total_length);
				end
			end
		end
	end

	initial begin
		int          phase;
		int          phase_end;
		int          random_base;
		int          kind;
		bit          first_seq;
		bit          chunked_sel;
		logic [31:0] limit;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Fixed length with the reset limit of zero: refused at once
		body_buf.push_back(8'h00);
		queue_body(1'b1, 1'b0);
		drain();
		write_reg(CFG_CHUNKED_MODE, 1);
		// One-byte chunk, LF-only trailer, then a full-width size saturates the total
		add_text("1");
		body_buf.push_back(CHAR_CR);
		body_buf.push_back(CHAR_LF);
		add_text("x");
		body_buf.push_back(CHAR_LF);
		add_text("FFFFFFFF");
		body_buf.push_back(CHAR_LF);
		queue_body(1'b1, 1'b0);
		// Ninth significant digit overflows the size
		add_text("100000000");
		queue_body(1'b1, 1'b0);
		// Second CR in a size line
		body_buf.push_back(CHAR_CR);
		body_buf.push_back(CHAR_CR);
		queue_body(1'b1, 1'b0);

		phase       = 0;
		random_base = fed_items;
		while (fed_items - random_base < RANDOM_ITEMS) begin
			drain();
			case (phase)
				0: begin
					chunked_sel = 1'b0;
					limit       = '1;
				end
				1: begin
					chunked_sel = 1'b1;
					limit       = '0;
				end
				default: begin
					chunked_sel = ($urandom_range(0, 3) != 0);
					case ($urandom_range(0, 5))
						0:       limit = '0;
						1:       limit = '1;
						2:       limit = $urandom();
						default: limit = $urandom_range(1, 40);
					endcase
				end
			endcase
			write_reg(CFG_CHUNKED_MODE, CFG_DATA_W'(chunked_sel));
			write_reg(CFG_BODY_LENGTH_LIMIT, limit);
			// long receiver hold-off while the sender keeps offering
			if (phase == 1)
				holdoff_req = 1'b1;
			phase_end = fed_items + $urandom_range(120, 260);
			first_seq = 1'b1;
			while (fed_items < phase_end) begin
				kind = $urandom_range(0, 9);
				if (kind == 0) begin
					queue_noise();
				end else begin
					if ((kind == 1) != mode_chunked)
						add_chunked_body();
					else
						add_length_body();
					// sometimes carry on with the body left from the last phase
					queue_body(!(first_seq && $urandom_range(0, 3) == 0), 1'b1);
				end
				first_seq = 1'b0;
			end
			phase++;
		end

		drain();
		repeat (8) @(posedge clk);
		if (fault_count == 0 && predicted_results.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

### files.f
+incdir+rtl
rtl/cbd_pkg.sv
rtl/cbd_cfg_regs.sv
rtl/cbd_core.sv
rtl/chunked_body_decoder_unit.sv
tb/testbench.sv
